// ===== rtl/core/recurrence_term_mod_prime_top_macros.svh =====
// assertion helpers used by rtmp_dp
`ifndef RECURRENCE_TERM_MOD_PRIME_TOP_MACROS_SVH
`define RECURRENCE_TERM_MOD_PRIME_TOP_MACROS_SVH

// same-cycle implication
`define RTMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define RTMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/rtmp_pkg.sv =====
`default_nettype none

package rtmp_pkg;

	localparam int INDEX_BITS = 64;
	localparam int VAL_W = 30;

	localparam logic [VAL_W-1:0] PRIME = 30'd1000000009;
	localparam logic [31:0] PRIME_32 = 32'd1000000009;
	localparam logic [31:0] PRIME_X2 = 32'd2000000018;

	// floor(2^60 / prime) for the barrett estimate
	localparam logic [63:0] MU_FULL = 64'h1000_0000_0000_0000 / 64'd1000000009;
	localparam logic [30:0] BARRETT_MU = MU_FULL[30:0];

	localparam logic [2:0] MAT_LAST = 3'd7;
	localparam logic [2:0] OUT_LAST = 3'd1;

	typedef logic [3:0][VAL_W-1:0] rtmp_mat_t;

	// entry index is {row, col}
	localparam rtmp_mat_t IDENT_MAT = '{30'd1, 30'd0, 30'd0, 30'd1};
	localparam rtmp_mat_t STEP_MAT = '{30'd0, 30'd1, 30'd2, 30'd1};
	localparam rtmp_mat_t PICK_F0_MAT = '{30'd0, 30'd1, 30'd1, 30'd0};

	typedef enum logic [1:0] {
		OP_ACC,
		OP_SQR,
		OP_OUT
	} rtmp_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PLAN,
		ST_ISSUE,
		ST_DRAIN,
		ST_DONE
	} rtmp_state_t;

	typedef struct packed {
		logic [1:0] entry;
		logic odd;
	} rtmp_tag_t;

	typedef struct packed {
		logic load;
		logic issue;
		logic [2:0] idx;
		rtmp_op_t kind;
		logic commit;
		logic shift;
		logic out_load;
	} rtmp_cmd_t;

	typedef struct packed {
		logic exp_zero;
		logic exp_lsb;
		logic exp_last;
		logic pipe_empty;
		logic out_free;
	} rtmp_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/rtmp_mulmod.sv =====
`default_nettype none

module rtmp_mulmod import rtmp_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_vld,
	input  wire logic [VAL_W-1:0] a,
	input  wire logic [VAL_W-1:0] b,
	input  wire rtmp_tag_t        in_tag,
	output logic                  out_vld,
	output logic [VAL_W-1:0]      res,
	output rtmp_tag_t             out_tag,
	output logic                  idle
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	rtmp_tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic [59:0] prod_s1;
	logic [30:0] q_s2;
	logic [31:0] xlo_s2;
	logic [31:0] r_s3;
	logic [VAL_W-1:0] res_s4;
	logic [61:0] qfull;
	logic [31:0] qp;
	logic [31:0] r1;
	logic [31:0] r2;

	always_comb begin
		qfull = 62'(prod_s1[59:29]) * 62'(BARRETT_MU);
		qp = {1'b0, q_s2} * PRIME_32;
		r1 = (r_s3 >= PRIME_X2) ? r_s3 - PRIME_X2 : r_s3;
		r2 = (r1 >= PRIME_32) ? r1 - PRIME_32 : r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 60'(a) * 60'(b);
		tag_s1 <= in_tag;
		q_s2 <= qfull[61:31];
		xlo_s2 <= prod_s1[31:0];
		tag_s2 <= tag_s1;
		r_s3 <= xlo_s2 - qp;
		tag_s3 <= tag_s2;
		res_s4 <= r2[VAL_W-1:0];
		tag_s4 <= tag_s3;
	end

	assign out_vld = vld_s4;
	assign res = res_s4;
	assign out_tag = tag_s4;
	assign idle = !(vld_s1 || vld_s2 || vld_s3 || vld_s4);

endmodule

`default_nettype wire

// ===== rtl/core/rtmp_dp.sv =====
`default_nettype none

`include "recurrence_term_mod_prime_top_macros.svh"

module rtmp_dp import rtmp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire rtmp_cmd_t             cmd,
	output rtmp_sts_t                  sts,
	input  wire logic [VAL_W-1:0]      start_zero,
	input  wire logic [VAL_W-1:0]      start_one,
	input  wire logic [INDEX_BITS-1:0] term_index,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output logic [VAL_W-1:0]           term_value
);

	function automatic logic [VAL_W-1:0] mod_fix(input logic [VAL_W-1:0] x);
		return (x >= PRIME) ? x - PRIME : x;
	endfunction

	function automatic logic [VAL_W-1:0] mod_add(input logic [VAL_W-1:0] x,
		input logic [VAL_W-1:0] y);
		logic [VAL_W:0] s;
		s = {1'b0, x} + {1'b0, y};
		return (s >= {1'b0, PRIME}) ? VAL_W'(s - {1'b0, PRIME}) : s[VAL_W-1:0];
	endfunction

	rtmp_mat_t acc_q, base_q, tmp_q;
	rtmp_mat_t lmat, rmat;
	logic [VAL_W-1:0] f0_q, f1_q, pend_q, term_value_q;
	logic [INDEX_BITS-1:0] e_q;
	logic res_valid_q;
	logic [VAL_W-1:0] op_a, op_b;
	rtmp_tag_t op_tag;
	logic mul_vld, mul_idle;
	logic [VAL_W-1:0] mul_res;
	rtmp_tag_t mul_tag;

	always_comb begin
		case (cmd.kind)
			OP_SQR: begin
				lmat = base_q;
				rmat = base_q;
			end
			OP_OUT: begin
				lmat = acc_q;
				rmat = '{'0, f0_q, '0, f1_q};
			end
			default: begin
				lmat = acc_q;
				rmat = base_q;
			end
		endcase
		op_a = lmat[{cmd.idx[2], cmd.idx[0]}];
		op_b = rmat[{cmd.idx[0], cmd.idx[1]}];
		op_tag.entry = cmd.idx[2:1];
		op_tag.odd = cmd.idx[0];
	end

	rtmp_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_vld  (cmd.issue),
		.a       (op_a),
		.b       (op_b),
		.in_tag  (op_tag),
		.out_vld (mul_vld),
		.res     (mul_res),
		.out_tag (mul_tag),
		.idle    (mul_idle)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			f0_q <= mod_fix(start_zero);
			f1_q <= mod_fix(start_one);
			base_q <= STEP_MAT;
			if (term_index == '0) begin
				acc_q <= PICK_F0_MAT;
				e_q <= '0;
			end else begin
				acc_q <= IDENT_MAT;
				e_q <= term_index - INDEX_BITS'(1);
			end
		end else begin
			if (cmd.commit && cmd.kind == OP_ACC) begin
				acc_q <= tmp_q;
			end
			if (cmd.commit && cmd.kind == OP_SQR) begin
				base_q <= tmp_q;
			end
			if (cmd.shift) begin
				e_q <= e_q >> 1;
			end
		end
		if (mul_vld) begin
			if (mul_tag.odd) begin
				tmp_q[mul_tag.entry] <= mod_add(pend_q, mul_res);
			end else begin
				pend_q <= mul_res;
			end
		end
		if (cmd.out_load) begin
			term_value_q <= tmp_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_comb begin
		sts.exp_zero = (e_q == '0);
		sts.exp_lsb = e_q[0];
		sts.exp_last = ((e_q >> 1) == '0);
		sts.pipe_empty = mul_idle;
		sts.out_free = !res_valid_q || !res_stall;
	end

	assign res_valid = res_valid_q;
	assign term_value = term_value_q;

	`RTMP_ASSERT_IMP(a_commit_drained, clk, arst_n, cmd.commit, mul_idle, "commit with products in flight")
	`RTMP_ASSERT_IMP(a_out_slot_free, clk, arst_n, cmd.out_load, !res_valid_q || !res_stall, "result overwritten")
	`RTMP_ASSERT_NXT(a_out_shown, clk, arst_n, cmd.out_load, res_valid_q, "loaded result not shown")
	`RTMP_ASSERT_IMP(a_mul_reduced, clk, arst_n, mul_vld, mul_res < PRIME, "product not fully reduced")
	`RTMP_ASSERT_IMP(a_res_reduced, clk, arst_n, res_valid_q, term_value_q < PRIME, "term not reduced")

endmodule

`default_nettype wire

// ===== rtl/core/rtmp_ctrl.sv =====
`default_nettype none

module rtmp_ctrl import rtmp_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      arg_valid,
	output logic           arg_stall,
	input  wire rtmp_sts_t sts,
	output rtmp_cmd_t      cmd
);

	rtmp_state_t state_q, state_d;
	rtmp_op_t kind_q, kind_d;
	logic [2:0] cnt_q, cnt_d;
	logic last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= OP_ACC;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			kind_q <= kind_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		kind_d = kind_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.idx = cnt_q;
		cmd.kind = kind_q;
		arg_stall = 1'b1;
		last = (kind_q == OP_OUT) ? (cnt_q == OUT_LAST) : (cnt_q == MAT_LAST);
		case (state_q)
			ST_IDLE: begin
				arg_stall = 1'b0;
				if (arg_valid) begin
					cmd.load = 1'b1;
					state_d = ST_PLAN;
				end
			end
			ST_PLAN: begin
				cnt_d = '0;
				if (sts.exp_zero) begin
					kind_d = OP_OUT;
				end else if (sts.exp_lsb) begin
					kind_d = OP_ACC;
				end else begin
					kind_d = OP_SQR;
				end
				state_d = ST_ISSUE;
			end
			ST_ISSUE: begin
				cmd.issue = 1'b1;
				if (last) begin
					cnt_d = '0;
					state_d = ST_DRAIN;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			ST_DRAIN: begin
				if (sts.pipe_empty) begin
					cmd.commit = 1'b1;
					case (kind_q)
						OP_OUT: begin
							state_d = ST_DONE;
						end
						OP_SQR: begin
							cmd.shift = 1'b1;
							state_d = ST_PLAN;
						end
						OP_ACC: begin
							if (sts.exp_last) begin
								cmd.shift = 1'b1;
								state_d = ST_PLAN;
							end else begin
								kind_d = OP_SQR;
								state_d = ST_ISSUE;
							end
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/core/recurrence_term_mod_prime_top.sv =====
// f(n) mod 1000000009 for f(n) = f(n-1) + 2 f(n-2) from start values f(0), f(1) and an
// index n (start values of the prime or above are reduced first). One item is worked on at a
// time; the next is taken once the current result sits in the output register, which holds it
// until the consumer takes it. Every matrix product is eight modular multiplies on one shared
// four-stage multiplier; each bit of n-1 costs one planning step and one squaring, plus one
// accumulate for a set bit, except that the top set bit skips its squaring. Taking the item,
// applying the power to (f1, f0) and loading the output register close the item; for n of 0
// or 1 no squaring or accumulate is done.
`default_nettype none

module recurrence_term_mod_prime_top import rtmp_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  arg_valid,
	output logic                       arg_stall,
	input  wire logic [VAL_W-1:0]      start_zero,
	input  wire logic [VAL_W-1:0]      start_one,
	input  wire logic [INDEX_BITS-1:0] term_index,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output logic [VAL_W-1:0]           term_value
);

	rtmp_cmd_t cmd;
	rtmp_sts_t sts;

	rtmp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.arg_valid (arg_valid),
		.arg_stall (arg_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	rtmp_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.start_zero (start_zero),
		.start_one  (start_one),
		.term_index (term_index),
		.res_valid  (res_valid),
		.res_stall  (res_stall),
		.term_value (term_value)
	);

endmodule

`default_nettype wire
